### rtl/wsts_pkg.sv
package wsts_pkg;

	// Field widths of the item and result transactions
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned WGT_W     = 32;
	localparam int unsigned FRAC_W    = 32;
	localparam int unsigned TOT_W     = 42;
	localparam int unsigned CNT_OUT_W = 11;

	// Operation codes
	localparam logic OP_SET    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [IDX_W-1:0]   leaf_index;
		logic [WGT_W-1:0]   weight;
		logic [FRAC_W-1:0]  random_fraction;
	} item_t;

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     chosen_index;
		logic [TOT_W-1:0]     total_weight;
		logic [CNT_OUT_W-1:0] nonzero_count;
	} result_t;

	// Datapath step selected by the controller
	typedef enum logic [3:0] {
		DP_CLEAR,
		DP_IDLE,
		DP_LEAF,
		DP_UP,
		DP_MUL_LO,
		DP_MUL_HI,
		DP_SUM,
		DP_DESC,
		DP_HOLD
	} dp_step_t;

	typedef struct packed {
		dp_step_t step;
		logic     load;
		logic     res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic op_sample;
		logic idx_ok;
		logic can_sample;
		logic out_free;
		logic clr_last;
	} dp_status_t;

endpackage

### rtl/wsts_ram.sv
module wsts_ram #(
	parameter int unsigned WIDTH = 42,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/wsts_datapath.sv
module wsts_datapath #(
	parameter int unsigned NUM_LEAVES  = 1024,
	parameter int unsigned WEIGHT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wsts_pkg::item_t     item,
	input  wsts_pkg::dp_cmd_t   cmd,
	output wsts_pkg::dp_status_t status,
	output logic                result_valid,
	input  logic                result_ready,
	output wsts_pkg::result_t   result
);

	import wsts_pkg::*;

	localparam int unsigned LOG_P  = $clog2(NUM_LEAVES);
	localparam int unsigned ADDR_W = LOG_P + 1;
	localparam int unsigned DEPTH  = 1 << ADDR_W;
	localparam int unsigned SUM_W  = WEIGHT_BITS + LOG_P;
	localparam int unsigned CNT_W  = $clog2(NUM_LEAVES + 1);
	localparam logic [63:0] WMASK  = (64'd1 << WEIGHT_BITS) - 64'd1;

	logic [ADDR_W-1:0] node_q, clr_q, ra, wa, nxt;
	logic [SUM_W-1:0]  w_q, acc_q, v_q, root_q, wd, rd_data, up_sum, v_next;
	logic [FRAC_W-1:0] r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LOG_P-1:0]  chosen_q;
	logic              found_q, we, go_right;
	logic [63:0]       total64, w64, prod, prod_lo_q, prod_hi_q;
	logic [31:0]       mul_b;
	result_t           res_q;

	wsts_ram #(
		.WIDTH(SUM_W),
		.DEPTH(DEPTH)
	) u_tree (
		.clk  (clk),
		.we   (we),
		.waddr(wa),
		.wdata(wd),
		.raddr(ra),
		.rdata(rd_data)
	);

	assign w64      = 64'(item.weight) & WMASK;
	assign up_sum   = acc_q + rd_data;
	assign go_right = !(v_q < rd_data);
	assign nxt      = {node_q[LOG_P-1:0], go_right};
	assign total64  = 64'(root_q);
	assign mul_b    = (cmd.step == DP_MUL_HI) ? total64[63:32] : total64[31:0];
	assign prod     = 64'(r_q) * 64'(mul_b);
	assign v_next   = SUM_W'(prod_hi_q + (prod_lo_q >> 32));

	// Tree memory port control
	always_comb begin
		we = 1'b0;
		wa = node_q;
		wd = w_q;
		ra = node_q ^ ADDR_W'(1);
		unique case (cmd.step)
			DP_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
			end
			DP_IDLE: ra = {1'b1, LOG_P'(item.leaf_index)};
			DP_LEAF: begin
				we = 1'b1;
			end
			DP_UP: begin
				we = 1'b1;
				wa = node_q >> 1;
				wd = up_sum;
				ra = (node_q >> 1) ^ ADDR_W'(1);
			end
			DP_SUM:  ra = ADDR_W'(2);
			DP_DESC: ra = {nxt[LOG_P-1:0], 1'b0};
			default: ;
		endcase
	end

	always_comb begin
		status.op_sample  = (item.operation == OP_SAMPLE);
		status.idx_ok     = (32'(item.leaf_index) < 32'(NUM_LEAVES));
		status.can_sample = (cnt_q != '0) && (root_q != '0);
		status.out_free   = !result_valid || result_ready;
		status.clr_last   = (clr_q == '1);
	end

	// Control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			cnt_q        <= '0;
			root_q       <= '0;
			found_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.step == DP_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.step == DP_LEAF) begin
				cnt_q <= cnt_q - CNT_W'(rd_data != '0) + CNT_W'(w_q != '0);
			end
			if (we && wa == ADDR_W'(1)) begin
				root_q <= wd;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.step == DP_SUM) begin
				found_q <= 1'b1;
			end
			if (cmd.res_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q   <= {1'b1, LOG_P'(item.leaf_index)};
			w_q      <= SUM_W'(w64);
			r_q      <= item.random_fraction;
			chosen_q <= '0;
		end
		unique case (cmd.step)
			DP_LEAF: acc_q <= w_q;
			DP_UP: begin
				acc_q  <= up_sum;
				node_q <= node_q >> 1;
			end
			DP_MUL_LO: prod_lo_q <= prod;
			DP_MUL_HI: prod_hi_q <= prod;
			DP_SUM: begin
				v_q    <= v_next;
				node_q <= ADDR_W'(1);
			end
			DP_DESC: begin
				v_q      <= go_right ? v_q - rd_data : v_q;
				node_q   <= nxt;
				chosen_q <= nxt[LOG_P-1:0];
			end
			default: ;
		endcase
		if (cmd.res_load) begin
			res_q.found         <= found_q;
			res_q.chosen_index  <= IDX_W'(chosen_q);
			res_q.total_weight  <= TOT_W'(root_q);
			res_q.nonzero_count <= CNT_OUT_W'(cnt_q);
		end
	end

	assign result = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(NUM_LEAVES))
		else $error("nonzero count above leaf count");

	a_pick_real_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.found) |-> (32'(result.chosen_index) < 32'(NUM_LEAVES)))
		else $error("sample landed on a padding leaf");

endmodule

### rtl/wsts_ctrl.sv
module wsts_ctrl #(
	parameter int unsigned LEVELS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  wsts_pkg::dp_status_t status,
	output wsts_pkg::dp_cmd_t    cmd
);

	import wsts_pkg::*;

	localparam int unsigned LVL_W = $clog2(LEVELS + 1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LEAF,
		S_UP,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_DESC,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [LVL_W-1:0] lvl_q;
	logic             lvl_last;

	assign lvl_last   = (lvl_q == LVL_W'(LEVELS - 1));
	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_CLEAR:  cmd.step = DP_CLEAR;
			S_IDLE:   cmd.step = DP_IDLE;
			S_LEAF:   cmd.step = DP_LEAF;
			S_UP:     cmd.step = DP_UP;
			S_MUL_LO: cmd.step = DP_MUL_LO;
			S_MUL_HI: cmd.step = DP_MUL_HI;
			S_SUM:    cmd.step = DP_SUM;
			S_DESC:   cmd.step = DP_DESC;
			default:  cmd.step = DP_HOLD;
		endcase
		cmd.load     = (state_q == S_IDLE) && item_valid;
		cmd.res_load = (state_q == S_DONE) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lvl_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (status.clr_last) state_q <= S_IDLE;
				S_IDLE: if (item_valid) begin
					if (status.op_sample) begin
						state_q <= status.can_sample ? S_MUL_LO : S_DONE;
					end else begin
						state_q <= status.idx_ok ? S_LEAF : S_DONE;
					end
				end
				S_LEAF: begin
					lvl_q   <= '0;
					state_q <= S_UP;
				end
				S_UP, S_DESC: begin
					if (lvl_last) begin
						state_q <= S_DONE;
					end else begin
						lvl_q <= lvl_q + LVL_W'(1);
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_SUM;
				S_SUM: begin
					lvl_q   <= '0;
					state_q <= S_DESC;
				end
				S_DONE: if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q != S_IDLE))
		else $error("accepted item did not start");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP || state_q == S_DESC) |-> (32'(lvl_q) < 32'(LEVELS)))
		else $error("tree level out of range");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !item_ready)
		else $error("item taken during clearing pass");

endmodule

### rtl/weighted_sum_tree_sampler.sv
// Weighted sum-tree sampler. Keeps NUM_LEAVES unsigned weights (WEIGHT_BITS wide, padded up
// to P = 2^ceil(log2(NUM_LEAVES)) leaves) in a binary sum tree held in one RAM of 2*P words,
// and returns exactly one result transaction per item transaction. A set operation writes a
// leaf and walks the sums up to the root; a sample scales the Q0.32 fraction by the root total
// and walks down to the chosen leaf. The tree RAM has one write and one registered read port,
// and each tree level takes one RAM access per cycle. A sample first scales the fraction with
// one 32x32 multiplier, taking the low and then the high half of the root total. A set with
// an out-of-range leaf, or a sample of an empty tree, goes straight to its result. One item
// is in work at a time; the next item is taken as soon as the previous result sits in the
// output register, even if that result has not yet been taken. An item that finishes while
// the previous result still waits holds its result until that one is taken. After reset the
// block sweeps all 2*P words of the RAM to zero, one word per cycle, before it accepts the
// first item.
module weighted_sum_tree_sampler #(
	parameter int unsigned NUM_LEAVES  = 1024,
	parameter int unsigned WEIGHT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  wsts_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output wsts_pkg::result_t result
);

	import wsts_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequence clearing, up-walks and descents
	wsts_ctrl #(
		.LEVELS($clog2(NUM_LEAVES))
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold the tree, the totals and the output register
	wsts_datapath #(
		.NUM_LEAVES (NUM_LEAVES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule
